FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the timer checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed: label");

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed: label");

`endif

FILE: rtl/dart_pkg.sv
// ----------------------------------------------------------------------------
// dart_pkg
// types, codes and the rate table of the divider and reload timer
// ----------------------------------------------------------------------------
package dart_pkg;

  localparam int unsigned CyclesW   = 6;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CtrlW     = 3;
  localparam int unsigned CountdnW  = 11;  // holds up to 1024
  localparam int unsigned TdataInW  = 16;
  localparam int unsigned TuserInW  = 2;
  localparam int unsigned TdataOutW = 8;
  localparam int unsigned TuserOutW = 1;

  localparam logic [CountdnW-1:0] CountdnReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_READ    = 2'd1,
    OP_WRITE   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_DIV    = 2'd0,
    REG_COUNT  = 2'd1,
    REG_RELOAD = 2'd2,
    REG_CTRL   = 2'd3
  } reg_sel_e;

  localparam int unsigned CtrlEnBit = 2;

  typedef struct packed {
    logic [7:0]         write_data;
    logic [1:0]         reg_select;
    logic [CyclesW-1:0] elapsed_cycles;
    logic [1:0]         opcode;
  } item_t;

  typedef struct packed {
    logic             timer_irq;
    logic [ByteW-1:0] read_data;
  } result_t;

  function automatic logic [CountdnW-1:0] period_of(input logic [1:0] rate);
    logic [CountdnW-1:0] p;
    unique case (rate)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/divider_and_reload_timer.sv
// ----------------------------------------------------------------------------
// divider_and_reload_timer
// divider, timer count, reload and control registers driven by an item stream
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries the opcode (advance, read,
// write), tdata the elapsed cycles, register select and write byte. Every item
// gives exactly one beat on the m_axis channel: tdata is the read byte (zero
// unless a read), tuser the overflow interrupt of an advance.
// An accepted item is held in the input register, is applied to the timer
// registers when the update stage steps and lands in the output register as
// it does so; its result is shown from there. One item per cycle is sustained
// while the receiver takes the results; the single update stage allows this,
// since each item sees the registers that the item before it left.
// Reset clears both stages and puts the timer registers at zero with the
// rate down-counter at 1024. When the receiver stalls, the result waits in
// the output register and one more item is still taken into the input
// register; only then does s_axis_tready_o drop.
// ----------------------------------------------------------------------------
module divider_and_reload_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [5:0] elapsed_cycles, [7:6] reg_select, [15:8] write_data
  input  logic [dart_pkg::TdataInW-1:0]   s_axis_tdata_i,
  // [1:0] opcode
  input  logic [dart_pkg::TuserInW-1:0]   s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] read_data
  output logic [dart_pkg::TdataOutW-1:0]  m_axis_tdata_o,
  // [0] timer_irq
  output logic [dart_pkg::TuserOutW-1:0]  m_axis_tuser_o
);

  logic              in_valid_q;
  dart_pkg::item_t   in_item_q;
  logic              out_valid_q;
  dart_pkg::result_t out_res_q;
  dart_pkg::result_t core_res;
  logic              step;
  logic              in_take;

  // the update stage moves when the output register is free or being emptied
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.opcode         <= s_axis_tuser_i;
      in_item_q.elapsed_cycles <= s_axis_tdata_i[5:0];
      in_item_q.reg_select     <= s_axis_tdata_i[7:6];
      in_item_q.write_data     <= s_axis_tdata_i[15:8];
    end
  end

  dart_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q.read_data;
  assign m_axis_tuser_o  = out_res_q.timer_irq;

endmodule

FILE: rtl/dart_core.sv
// ----------------------------------------------------------------------------
// dart_core
// timer registers and the single-pass update for one item
// ----------------------------------------------------------------------------
module dart_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  dart_pkg::item_t  item_i,
  output dart_pkg::result_t res_o
);

  logic [dart_pkg::ByteW-1:0]    prescale_q, prescale_d;
  logic [dart_pkg::ByteW-1:0]    divider_q, divider_d;
  logic [dart_pkg::CountdnW-1:0] countdn_q, countdn_d;
  logic [dart_pkg::ByteW-1:0]    count_q, count_d;
  logic [dart_pkg::ByteW-1:0]    reload_q, reload_d;
  logic [dart_pkg::CtrlW-1:0]    ctrl_q, ctrl_d;

  logic [dart_pkg::ByteW:0]      acc;
  logic [dart_pkg::CtrlW-1:0]    new_ctrl;
  dart_pkg::op_e                 op;
  dart_pkg::reg_sel_e            sel;

  assign op  = dart_pkg::op_e'(item_i.opcode);
  assign sel = dart_pkg::reg_sel_e'(item_i.reg_select);

  always_comb begin
    prescale_d = prescale_q;
    divider_d  = divider_q;
    countdn_d  = countdn_q;
    count_d    = count_q;
    reload_d   = reload_q;
    ctrl_d     = ctrl_q;
    res_o      = '0;
    acc        = {1'b0, prescale_q} + {3'b000, item_i.elapsed_cycles};
    new_ctrl   = item_i.write_data[dart_pkg::CtrlW-1:0];

    case (op)
      dart_pkg::OP_ADVANCE: begin
        // carry out of the prescaler is one divider tick, remainder kept
        prescale_d = acc[dart_pkg::ByteW-1:0];
        if (acc[dart_pkg::ByteW]) begin
          divider_d = divider_q + 8'd1;
        end
        if (ctrl_q[dart_pkg::CtrlEnBit]) begin
          if (countdn_q <= {5'b00000, item_i.elapsed_cycles}) begin
            countdn_d = dart_pkg::period_of(ctrl_q[1:0]);
            if (count_q == 8'hff) begin
              count_d         = reload_q;
              res_o.timer_irq = 1'b1;
            end else begin
              count_d = count_q + 8'd1;
            end
          end else begin
            countdn_d = countdn_q - {5'b00000, item_i.elapsed_cycles};
          end
        end
      end
      dart_pkg::OP_READ: begin
        unique case (sel)
          dart_pkg::REG_DIV:    res_o.read_data = divider_q;
          dart_pkg::REG_COUNT:  res_o.read_data = count_q;
          dart_pkg::REG_RELOAD: res_o.read_data = reload_q;
          default:              res_o.read_data = {5'b00000, ctrl_q};
        endcase
      end
      dart_pkg::OP_WRITE: begin
        unique case (sel)
          dart_pkg::REG_DIV:    divider_d = '0;
          dart_pkg::REG_COUNT:  count_d   = item_i.write_data;
          dart_pkg::REG_RELOAD: reload_d  = item_i.write_data;
          default: begin
            // a changed rate select restarts the down-counter
            if (new_ctrl[1:0] != ctrl_q[1:0]) begin
              countdn_d = dart_pkg::period_of(new_ctrl[1:0]);
            end
            ctrl_d = new_ctrl;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      divider_q  <= '0;
      countdn_q  <= dart_pkg::CountdnReset;
      count_q    <= '0;
      reload_q   <= '0;
      ctrl_q     <= '0;
    end else if (step_i) begin
      prescale_q <= prescale_d;
      divider_q  <= divider_d;
      countdn_q  <= countdn_d;
      count_q    <= count_d;
      reload_q   <= reload_d;
      ctrl_q     <= ctrl_d;
    end
  end

endmodule

FILE: rtl/dart_checker.sv
// ----------------------------------------------------------------------------
// dart_port_checker
// port-level checks of the divider and reload timer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dart_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [dart_pkg::TdataOutW-1:0] m_axis_tdata_o,
  input logic [dart_pkg::TuserOutW-1:0] m_axis_tuser_o
);

  logic out_stall;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a stalled result beat holds
  `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable({m_axis_tuser_o, m_axis_tdata_o}))

  // input backpressure only ever comes from a full output register
  `ASSERT_CLK(a_ready_needs_full, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)

  // an interrupt comes only from an advance, which reads nothing
  `ASSERT_CLK(a_irq_no_data, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)

  // no result beat straight out of reset
  `ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !m_axis_tvalid_o)

endmodule

bind divider_and_reload_timer dart_port_checker u_dart_checker (.*);
